// File: hw/rtl/sfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfp_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int POS_W = $clog2(MAX_PAYLOAD + 8);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef logic [1:0] stat_code_t;
	localparam stat_code_t STAT_OK  = 2'd0;
	localparam stat_code_t STAT_OVF = 2'd1;
	localparam stat_code_t STAT_END = 2'd2;
	localparam stat_code_t STAT_CRC = 2'd3;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_START_HIGH = 2'd0;
	localparam reg_idx_t REG_START_LOW  = 2'd1;
	localparam reg_idx_t REG_END_HIGH   = 2'd2;
	localparam reg_idx_t REG_END_LOW    = 2'd3;

	typedef struct packed {
		logic [7:0] start_high;
		logic [7:0] start_low;
		logic [7:0] end_high;
		logic [7:0] end_low;
	} cfg_t;

	typedef struct packed {
		logic       clear;
		logic       body_step;
		logic       emit;
		stat_code_t emit_code;
		logic       drain_step;
	} ctl_cmd_t;

	typedef struct packed {
		logic start_high_hit;
		logic start_low_hit;
		logic ovf;
		logic frame_end;
		logic end_bad;
		logic crc_bad;
		logic len_zero;
		logic drain_last;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/serial_frame_parser_crc16_core.sv
// Framed byte stream parser with CRC-16/CCITT-FALSE check.
// Input channel: in_valid / in_stall carries one received byte (rx_byte) per word.
// Output channel: out_valid / out_stall carries one result word (status, frame_ready,
// command_word, payload_count, payload_byte, byte_index, last).
// Register port: APB-style, start_high at 0x0, start_low at 0x4, end_high at 0x8,
// end_low at 0xC; write only while the parser is idle.
// Throughput: one input byte per cycle while not draining and no result is held stalled.
// Results: error and empty-frame results enter the output register in the cycle
// after the byte that ends them is taken (the length byte for overflow, else the
// final end marker byte); a good frame drains from the payload store one result per
// cycle while out_stall is low, and the input is stalled until its last byte drains.
// Stall: while a result sits in the output register with out_stall high the parser
// stops taking bytes; the held word does not change.
// Reset: parser returns to the start-marker hunt, registers take their defaults
// (0xAA, 0x55, 0x55, 0xAA); no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_parser_crc16_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        frame_ready,
	output logic [15:0] command_word,
	output logic [5:0]  payload_count,
	output logic [7:0]  payload_byte,
	output logic [4:0]  byte_index,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sfp_pkg::*;

	cfg_t     cfg_q;
	ctl_cmd_t cmd;
	dp_stat_t stat;
	reg_idx_t reg_idx;
	logic     wr_en;
	logic [7:0] rd_val;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_high <= 8'hAA;
			cfg_q.start_low  <= 8'h55;
			cfg_q.end_high   <= 8'h55;
			cfg_q.end_low    <= 8'hAA;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_START_HIGH: cfg_q.start_high <= pwdata[7:0];
				REG_START_LOW:  cfg_q.start_low  <= pwdata[7:0];
				REG_END_HIGH:   cfg_q.end_high   <= pwdata[7:0];
				REG_END_LOW:    cfg_q.end_low    <= pwdata[7:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_START_HIGH: rd_val = cfg_q.start_high;
			REG_START_LOW:  rd_val = cfg_q.start_low;
			REG_END_HIGH:   rd_val = cfg_q.end_high;
			REG_END_LOW:    rd_val = cfg_q.end_low;
			default:        rd_val = 8'h00;
		endcase
	end

	assign prdata = {24'h000000, rd_val};

	sfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	sfp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.rx_byte       (rx_byte),
		.out_stall     (out_stall),
		.stat          (stat),
		.out_valid     (out_valid),
		.status        (status),
		.frame_ready   (frame_ready),
		.command_word  (command_word),
		.payload_count (payload_count),
		.payload_byte  (payload_byte),
		.byte_index    (byte_index),
		.last          (last)
	);

`ifndef ASSERT_OFF
	a_no_take_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !(out_valid && out_stall))
		else $error("byte taken while result word held");

	a_error_word_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != STAT_OK)) |->
		(last && !frame_ready && (command_word == 16'h0000) && (payload_count == 6'd0)))
		else $error("error word malformed");

	a_ok_is_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STAT_OK)) |-> frame_ready)
		else $error("ok word without frame_ready");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_ready && (payload_count != 6'd0)) |->
		({1'b0, byte_index} < payload_count))
		else $error("byte_index beyond payload_count");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/sfp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sfp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  sfp_pkg::dp_stat_t  stat,
	output logic               in_stall,
	output sfp_pkg::ctl_cmd_t  cmd
);
	import sfp_pkg::*;

	typedef enum logic [3:0] {
		S_HUNT  = 4'b0001,
		S_SYNC  = 4'b0010,
		S_BODY  = 4'b0100,
		S_DRAIN = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   acc;

	assign in_stall = (state_q == S_DRAIN) || !stat.out_free;
	assign acc      = in_valid && !in_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_HUNT: begin
				if (acc && stat.start_high_hit) begin
					state_d = S_SYNC;
				end
			end
			S_SYNC: begin
				if (acc) begin
					priority if (stat.start_low_hit) begin
						state_d = S_BODY;
					end else if (stat.start_high_hit) begin
						state_d = S_SYNC;
					end else begin
						state_d = S_HUNT;
					end
				end
			end
			S_BODY: begin
				if (acc) begin
					cmd.body_step = 1'b1;
					if (stat.ovf) begin
						cmd.emit      = 1'b1;
						cmd.emit_code = STAT_OVF;
						cmd.clear     = 1'b1;
						state_d       = S_HUNT;
					end else if (stat.frame_end) begin
						priority if (stat.end_bad) begin
							cmd.emit      = 1'b1;
							cmd.emit_code = STAT_END;
							cmd.clear     = 1'b1;
							state_d       = S_HUNT;
						end else if (stat.crc_bad) begin
							cmd.emit      = 1'b1;
							cmd.emit_code = STAT_CRC;
							cmd.clear     = 1'b1;
							state_d       = S_HUNT;
						end else if (stat.len_zero) begin
							cmd.emit      = 1'b1;
							cmd.emit_code = STAT_OK;
							cmd.clear     = 1'b1;
							state_d       = S_HUNT;
						end else begin
							state_d = S_DRAIN;
						end
					end
				end
			end
			S_DRAIN: begin
				if (stat.out_free) begin
					cmd.drain_step = 1'b1;
					if (stat.drain_last) begin
						cmd.clear = 1'b1;
						state_d   = S_HUNT;
					end
				end
			end
			default: begin
				state_d = S_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sfp_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sfp_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  sfp_pkg::cfg_t       cfg,
	input  sfp_pkg::ctl_cmd_t   cmd,
	input  logic [7:0]          rx_byte,
	input  logic                out_stall,
	output sfp_pkg::dp_stat_t   stat,
	output logic                out_valid,
	output logic [1:0]          status,
	output logic                frame_ready,
	output logic [15:0]         command_word,
	output logic [5:0]          payload_count,
	output logic [7:0]          payload_byte,
	output logic [4:0]          byte_index,
	output logic                last
);
	import sfp_pkg::*;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	logic [POS_W-1:0] pos_q;
	logic [15:0]      crc_q;
	logic [15:0]      cmd_q;
	logic [7:0]       len_hi_q;
	logic [LEN_W-1:0] len_q;
	logic [15:0]      rcrc_q;
	logic             end_ok_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       mem [MAX_PAYLOAD];

	logic [POS_W-1:0] k;
	logic [POS_W-1:0] len_ext;
	logic             past_hdr;
	logic             in_payload;
	logic             out_valid_q;

	assign k          = pos_q - POS_W'(4);
	assign len_ext    = POS_W'(len_q);
	assign past_hdr   = pos_q >= POS_W'(4);
	assign in_payload = past_hdr && (k < len_ext);

	assign stat.start_high_hit = rx_byte == cfg.start_high;
	assign stat.start_low_hit  = rx_byte == cfg.start_low;
	assign stat.ovf            = (pos_q == POS_W'(3)) &&
	                             ((len_hi_q != 8'h00) || (rx_byte > 8'(MAX_PAYLOAD)));
	assign stat.frame_end      = past_hdr && (k == len_ext + POS_W'(3));
	assign stat.end_bad        = !end_ok_q || (rx_byte != cfg.end_low);
	assign stat.crc_bad        = rcrc_q != crc_q;
	assign stat.len_zero       = len_q == '0;
	assign stat.drain_last     = (LEN_W'(idx_q) + LEN_W'(1)) == len_q;
	assign stat.out_free       = !out_valid_q || !out_stall;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			crc_q    <= CRC_INIT;
			cmd_q    <= '0;
			len_hi_q <= '0;
			len_q    <= '0;
			rcrc_q   <= '0;
			end_ok_q <= 1'b0;
			idx_q    <= '0;
		end else if (cmd.clear) begin
			pos_q    <= '0;
			crc_q    <= CRC_INIT;
			cmd_q    <= '0;
			len_hi_q <= '0;
			len_q    <= '0;
			rcrc_q   <= '0;
			end_ok_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (cmd.drain_step) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.body_step) begin
				pos_q <= pos_q + POS_W'(1);
				priority if (pos_q < POS_W'(2)) begin
					cmd_q <= {cmd_q[7:0], rx_byte};
					crc_q <= crc_byte(crc_q, rx_byte);
				end else if (pos_q == POS_W'(2)) begin
					len_hi_q <= rx_byte;
					crc_q    <= crc_byte(crc_q, rx_byte);
				end else if (pos_q == POS_W'(3)) begin
					len_q <= LEN_W'(rx_byte);
					crc_q <= crc_byte(crc_q, rx_byte);
				end else if (in_payload) begin
					crc_q <= crc_byte(crc_q, rx_byte);
				end else if (k == len_ext) begin
					rcrc_q[15:8] <= rx_byte;
				end else if (k == len_ext + POS_W'(1)) begin
					rcrc_q[7:0] <= rx_byte;
				end else if (k == len_ext + POS_W'(2)) begin
					end_ok_q <= rx_byte == cfg.end_high;
				end else begin
					end_ok_q <= end_ok_q;
				end
			end
		end
	end

	// payload store
	always_ff @(posedge clk) begin
		if (cmd.body_step && in_payload) begin
			mem[k[IDX_W-1:0]] <= rx_byte;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.drain_step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status        <= cmd.emit_code;
			frame_ready   <= cmd.emit_code == STAT_OK;
			command_word  <= (cmd.emit_code == STAT_OK) ? cmd_q : 16'h0000;
			payload_count <= '0;
			payload_byte  <= '0;
			byte_index    <= '0;
			last          <= 1'b1;
		end else if (cmd.drain_step) begin
			status        <= STAT_OK;
			frame_ready   <= 1'b1;
			command_word  <= cmd_q;
			payload_count <= 6'(len_q);
			payload_byte  <= mem[idx_q];
			byte_index    <= 5'(idx_q);
			last          <= stat.drain_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
